@@ rtl/twsm_pkg.sv @@
// shared types, codes and level tables for the two-wire sensor measure master
package twsm_pkg;

    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [3:0]  RESET_PULSES = 4'd9;
    localparam logic [3:0]  BYTE_BITS    = 4'd8;
    localparam logic [15:0] TIMEOUT_RST  = 16'd55535;
    localparam logic [7:0]  PHASE_RST    = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 1'b0,
        CFG_PHASE   = 1'b1
    } t_cfg_idx;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'd0,
        ST_RST_PRE = 6'd1,
        ST_RST_HI  = 6'd2,
        ST_RST_LO  = 6'd3,
        ST_START0  = 6'd4,
        ST_START1  = 6'd5,
        ST_START2  = 6'd6,
        ST_START3  = 6'd7,
        ST_START4  = 6'd8,
        ST_START5  = 6'd9,
        ST_START6  = 6'd10,
        ST_WR_SET  = 6'd11,
        ST_WR_HI   = 6'd12,
        ST_ACK_SET = 6'd13,
        ST_ACK_HI  = 6'd14,
        ST_ACK_LO  = 6'd15,
        ST_WAIT    = 6'd16,
        ST_RD1_SET = 6'd17,
        ST_RD1_HI  = 6'd18,
        ST_RA1_SET = 6'd19,
        ST_RA1_HI  = 6'd20,
        ST_RA1_LO  = 6'd21,
        ST_RD2_SET = 6'd22,
        ST_RD2_HI  = 6'd23,
        ST_RA2_SET = 6'd24,
        ST_RA2_HI  = 6'd25,
        ST_RA2_LO  = 6'd26
    } t_step;

    typedef struct packed {
        logic       start_req;
        logic [7:0] command;
        logic       begin_with_reset;
        logic       data_in;
    } t_in_word;

    typedef struct packed {
        logic        sck;
        logic        data_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] reading;
        logic        no_ack;
        logic        timed_out;
    } t_out_word;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [7:0]  phase_ticks;
    } t_cfg;

    // clock level per phased step
    function automatic logic sck_level(input t_step s);
        logic lvl;
        case (s)
            ST_RST_HI, ST_START1, ST_START2, ST_START4, ST_START5, ST_WR_HI,
            ST_ACK_HI, ST_RD1_HI, ST_RA1_HI, ST_RD2_HI, ST_RA2_HI: lvl = 1'b1;
            default: lvl = 1'b0;
        endcase
        return lvl;
    endfunction

    // data level per phased step
    function automatic logic dat_level(input t_step s);
        logic lvl;
        case (s)
            ST_START2, ST_START3, ST_START4, ST_RA1_SET, ST_RA1_HI: lvl = 1'b0;
            default: lvl = 1'b1;
        endcase
        return lvl;
    endfunction

endpackage

@@ rtl/two_wire_sensor_measure_master_unit.sv @@
// top level of the two-wire sensor measure master
//
// usage:
//   each input word is one tick of bus timing: start request, command byte,
//   reset-first flag and the sampled data line level
//   each accepted input word yields exactly one output word: the clock and
//   data levels for that tick, busy and done, the shift register contents
//   and the no-acknowledge and timeout flags
//   the sequencer state advances once per accepted word and the result sits
//   in an output register, valid in the cycle after the word is taken, and a
//   word is taken every cycle while the output side keeps up
//   a word can be accepted while the previous result waits, as long as the
//   output register is drained in the same cycle; when the receiver stalls
//   with a result held, the input is stalled and the held word is kept
//   reset (synchronous, active low) returns the sequencer to idle, clears the
//   flags and reading, empties the output register and loads the timeout
//   register with 55535 and the phase register with 1; configuration writes
//   take effect at the next edge; the user makes them while idle, unchecked
module two_wire_sensor_measure_master_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [twsm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [twsm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  twsm_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output twsm_pkg::t_out_word                o_out_word
);

    twsm_pkg::t_cfg      cfg;
    twsm_pkg::t_out_word res;
    twsm_pkg::t_out_word r_out;
    logic                r_out_valid;
    logic                adv;

    twsm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    twsm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_word  (i_in_word),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign o_in_stall = r_out_valid & i_out_stall;
    assign adv        = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ rtl/twsm_cfg_regs.sv @@
// configuration registers for timeout and phase length
module twsm_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [twsm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [twsm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output twsm_pkg::t_cfg                     o_cfg
);

    twsm_pkg::t_cfg r_cfg;
    twsm_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (twsm_pkg::t_cfg_idx'(i_cfg_idx))
                twsm_pkg::CFG_TIMEOUT: n_cfg.timeout_ticks = i_cfg_data;
                twsm_pkg::CFG_PHASE:   n_cfg.phase_ticks   = i_cfg_data[7:0];
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= twsm_pkg::TIMEOUT_RST;
            r_cfg.phase_ticks   <= twsm_pkg::PHASE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/twsm_seq.sv @@
// bus sequencer: one tick of clock and data timing per accepted word
module twsm_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  twsm_pkg::t_in_word    i_word,
    input  twsm_pkg::t_cfg        i_cfg,
    output twsm_pkg::t_out_word   o_res
);

    twsm_pkg::t_step r_step, n_step;
    logic [3:0]  r_bit, n_bit;
    logic [15:0] r_shift, n_shift;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_phase, n_phase;
    logic [15:0] r_wait, n_wait;
    logic        r_retry, n_retry;
    logic [1:0]  r_flags, n_flags;

    logic [7:0]  plen;
    logic [7:0]  phase_inc;
    logic [15:0] wait_inc;
    logic [3:0]  bit_inc;
    logic        d;

    always_comb begin
        n_step    = r_step;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_cmd     = r_cmd;
        n_phase   = r_phase;
        n_wait    = r_wait;
        n_retry   = r_retry;
        n_flags   = r_flags;
        d         = i_word.data_in;
        plen      = (i_cfg.phase_ticks == 8'd0) ? 8'd1 : i_cfg.phase_ticks;
        phase_inc = r_phase + 8'd1;
        wait_inc  = r_wait + 16'd1;
        bit_inc   = r_bit + 4'd1;
        o_res     = '0;
        o_res.data_out = 1'b1;

        case (r_step)
            twsm_pkg::ST_IDLE: begin
                if (i_word.start_req) begin
                    n_cmd   = i_word.command;
                    n_retry = 1'b0;
                    n_flags = 2'b00;
                    n_bit   = 4'd0;
                    n_phase = 8'd0;
                    n_wait  = 16'd0;
                    n_step  = i_word.begin_with_reset ? twsm_pkg::ST_RST_PRE
                                                      : twsm_pkg::ST_START0;
                    o_res.busy_res = 1'b1;
                end
            end
            twsm_pkg::ST_WAIT: begin
                o_res.busy_res = 1'b1;
                if (!d) begin
                    n_bit   = 4'd0;
                    n_phase = 8'd0;
                    n_step  = twsm_pkg::ST_RD1_SET;
                end else begin
                    n_wait = wait_inc;
                    if (wait_inc >= i_cfg.timeout_ticks || wait_inc == 16'd0) begin
                        n_flags[1] = 1'b1;
                        n_bit      = 4'd0;
                        n_phase    = 8'd0;
                        n_step     = twsm_pkg::ST_RD1_SET;
                    end
                end
            end
            default: begin
                if (r_step <= twsm_pkg::ST_RA2_LO) begin
                    o_res.busy_res = 1'b1;
                    o_res.sck      = twsm_pkg::sck_level(r_step);
                    o_res.data_out = twsm_pkg::dat_level(r_step);
                    if (r_step == twsm_pkg::ST_WR_SET || r_step == twsm_pkg::ST_WR_HI) begin
                        o_res.data_out = r_cmd[3'd7 - r_bit[2:0]];
                    end
                    n_phase = phase_inc;
                    if (phase_inc >= plen || phase_inc == 8'd0) begin
                        n_phase = 8'd0;
                        // end of phase
                        case (r_step)
                            twsm_pkg::ST_RST_PRE: begin
                                n_bit  = 4'd0;
                                n_step = twsm_pkg::ST_RST_HI;
                            end
                            twsm_pkg::ST_RST_HI: n_step = twsm_pkg::ST_RST_LO;
                            twsm_pkg::ST_RST_LO: begin
                                n_bit  = bit_inc;
                                n_step = (bit_inc >= twsm_pkg::RESET_PULSES)
                                         ? twsm_pkg::ST_START0 : twsm_pkg::ST_RST_HI;
                            end
                            twsm_pkg::ST_START6: begin
                                n_bit  = 4'd0;
                                n_step = twsm_pkg::ST_WR_SET;
                            end
                            twsm_pkg::ST_WR_SET: n_step = twsm_pkg::ST_WR_HI;
                            twsm_pkg::ST_WR_HI: begin
                                n_bit  = bit_inc;
                                n_step = (bit_inc >= twsm_pkg::BYTE_BITS)
                                         ? twsm_pkg::ST_ACK_SET : twsm_pkg::ST_WR_SET;
                            end
                            twsm_pkg::ST_ACK_SET: n_step = twsm_pkg::ST_ACK_HI;
                            twsm_pkg::ST_ACK_HI: begin
                                n_flags[0] = d;
                                n_step     = twsm_pkg::ST_ACK_LO;
                            end
                            twsm_pkg::ST_ACK_LO: begin
                                if (r_flags[0] && !r_retry) begin
                                    n_retry    = 1'b1;
                                    n_flags[0] = 1'b0;
                                    n_step     = twsm_pkg::ST_RST_PRE;
                                end else begin
                                    n_wait = 16'd0;
                                    n_step = twsm_pkg::ST_WAIT;
                                end
                            end
                            twsm_pkg::ST_RD1_SET: n_step = twsm_pkg::ST_RD1_HI;
                            twsm_pkg::ST_RD2_SET: n_step = twsm_pkg::ST_RD2_HI;
                            twsm_pkg::ST_RD1_HI, twsm_pkg::ST_RD2_HI: begin
                                n_shift = {r_shift[14:0], d};
                                n_bit   = bit_inc;
                                if (bit_inc >= twsm_pkg::BYTE_BITS) begin
                                    n_step = (r_step == twsm_pkg::ST_RD1_HI)
                                             ? twsm_pkg::ST_RA1_SET : twsm_pkg::ST_RA2_SET;
                                end else begin
                                    n_step = (r_step == twsm_pkg::ST_RD1_HI)
                                             ? twsm_pkg::ST_RD1_SET : twsm_pkg::ST_RD2_SET;
                                end
                            end
                            twsm_pkg::ST_RA1_LO: begin
                                n_bit  = 4'd0;
                                n_step = twsm_pkg::ST_RD2_SET;
                            end
                            twsm_pkg::ST_RA2_LO: begin
                                n_step         = twsm_pkg::ST_IDLE;
                                o_res.done_res = 1'b1;
                            end
                            twsm_pkg::ST_START0, twsm_pkg::ST_START1, twsm_pkg::ST_START2,
                            twsm_pkg::ST_START3, twsm_pkg::ST_START4, twsm_pkg::ST_START5,
                            twsm_pkg::ST_RA1_SET, twsm_pkg::ST_RA1_HI,
                            twsm_pkg::ST_RA2_SET, twsm_pkg::ST_RA2_HI: begin
                                n_step = twsm_pkg::t_step'(6'(r_step) + 6'd1);
                            end
                            default: n_step = twsm_pkg::ST_IDLE;
                        endcase
                    end
                end else begin
                    n_step = twsm_pkg::ST_IDLE;
                end
            end
        endcase

        o_res.reading   = n_shift;
        o_res.no_ack    = n_flags[0];
        o_res.timed_out = n_flags[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= twsm_pkg::ST_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_cmd   <= '0;
            r_phase <= '0;
            r_wait  <= '0;
            r_retry <= 1'b0;
            r_flags <= '0;
        end else if (i_adv) begin
            r_step  <= n_step;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_retry <= n_retry;
            r_flags <= n_flags;
        end
    end

endmodule
